>>> rtl/exif_thumbnail_locator_assert.svh
// Assertion macros used by the thumbnail locator datapath.
`ifndef EXIF_THUMBNAIL_LOCATOR_ASSERT_SVH
`define EXIF_THUMBNAIL_LOCATOR_ASSERT_SVH

// Same-cycle implication.
`define ETL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("etl assertion failed");

// Next-cycle implication.
`define ETL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("etl assertion failed");

`endif

>>> rtl/etl_pkg.sv
// Types, codes and signature tables for the thumbnail locator.
package etl_pkg;

  localparam int unsigned EtlWindowBytes = 65536;

  typedef logic [2:0] etl_status_t;
  localparam etl_status_t StFound   = 3'd0;
  localparam etl_status_t StNone    = 3'd1;
  localparam etl_status_t StNotJpeg = 3'd2;
  localparam etl_status_t StNoExif  = 3'd3;
  localparam etl_status_t StWindow  = 3'd4;

  localparam logic [15:0] TagThumbOffset = 16'h0201;
  localparam logic [15:0] TagThumbSize   = 16'h0202;
  localparam logic [15:0] TagExifIfd     = 16'h8769;

  localparam logic [7:0]  MarkFf  = 8'hFF;
  localparam logic [7:0]  MarkSoi = 8'hD8;

  localparam logic [31:0] RafLenPos  = 32'h54;
  localparam logic [31:0] RafLenEnd  = 32'h57;
  localparam logic [31:0] RafMinSkip = 32'h58;
  localparam logic [31:0] RafMagicEnd = 32'd14;
  localparam logic [31:0] BaseExif   = 32'h12 - 32'h06;
  localparam logic [31:0] BaseJfif   = 32'h1E;

  typedef enum logic [1:0] {SrcFour, SrcAt, SrcAt8} etl_src_e;

  typedef struct packed {
    logic        clear;
    logic        byte_en;
    logic        shift_en;
    logic        jpeg_en;
    logic        tiff_en;
    logic        rd_start;
    etl_src_e    rd_src;
    logic        rd_two;
    logic        at_word;
    logic        at_sub;
    logic        at_add2;
    logic        ent_load;
    logic        ent_apply;
    logic        next_load;
    logic        tag_load;
    logic        out_load;
    etl_status_t out_status;
  } etl_cmd_t;

  typedef struct packed {
    logic magic_match;
    logic pos_zero;
    logic pos_magic_end;
    logic pos_len_end;
    logic skip_short;
    logic pos_at_skip;
    logic jpeg_bad;
    logic jpeg_nosig;
    logic jpeg_tiff;
    logic rd_done;
    logic rd_fail;
    logic ent_zero;
    logic thumb_bad;
    logic word_zero;
    logic sub_zero;
    logic found;
  } etl_sts_t;

  function automatic logic [7:0] raf_byte(logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:  v = 8'h46;
      4'd1:  v = 8'h55;
      4'd2:  v = 8'h4A;
      4'd3:  v = 8'h49;
      4'd4:  v = 8'h46;
      4'd5:  v = 8'h49;
      4'd6:  v = 8'h4C;
      4'd7:  v = 8'h4D;
      4'd8:  v = 8'h43;
      4'd9:  v = 8'h43;
      4'd10: v = 8'h44;
      4'd11: v = 8'h2D;
      4'd12: v = 8'h52;
      4'd13: v = 8'h41;
      4'd14: v = 8'h57;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] jfif_byte(logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0: v = 8'h4A;
      2'd1: v = 8'h46;
      2'd2: v = 8'h49;
      default: v = 8'h46;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] exif_byte(logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'h45;
      3'd1: v = 8'h78;
      3'd2: v = 8'h69;
      3'd3: v = 8'h66;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/exif_thumbnail_locator.sv
// Top level of the Exif thumbnail locator: byte stream in, one status transaction per file.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid_i/tready_o      tdata[7:0] data_byte, tlast last_byte
//  m_axis    out  m_axis_tvalid_o/tready_i      tdata[2:0] status, [34:3] offset,
//                                               [66:35] length, [71:67] zero
//
// Header and TIFF bytes are taken at one per cycle while the input side is ready.
// After the last byte the IFD walk reads the window memory byte by byte: the IFD0 offset,
// then per IFD visited its entry count and each entry's tag and value, plus the IFD1
// pointer; input held off meanwhile.
// Reset is asynchronous and leaves the block waiting for the first byte of a file.
// The result sits in an output register; the next file's bytes flow while it waits.
module exif_thumbnail_locator import etl_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = EtlWindowBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // status, thumb_offset, thumb_length, pad
);

  etl_cmd_t    cmd;
  etl_sts_t    sts;
  etl_status_t out_status;
  logic [31:0] out_offset, out_length;

  etl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  etl_dp #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_i       (s_axis_tdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_status_o (out_status),
    .out_offset_o (out_offset),
    .out_length_o (out_length)
  );

  assign m_axis_tdata_o = {5'd0, out_length, out_offset, out_status};

endmodule

>>> rtl/etl_dp.sv
// Datapath: header counters, TIFF window memory, word reader and IFD registers.
`include "exif_thumbnail_locator_assert.svh"
module etl_dp import etl_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = EtlWindowBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_i,
  input  etl_cmd_t    cmd_i,
  output etl_sts_t    sts_o,
  output etl_status_t out_status_o,
  output logic [31:0] out_offset_o,
  output logic [31:0] out_length_o
);

  localparam int unsigned AW = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
  localparam int unsigned FW = $clog2(WINDOW_BYTES + 1);
  localparam logic [FW-1:0] FillMax = FW'(WINDOW_BYTES);

  logic [31:0]   pos_q, skip_q, base_q, next_q, sub_q, foff_q, fsize_q, word_q;
  logic [32:0]   len_q;
  logic [FW-1:0] fill_q;
  logic [7:0]    hrel_q;
  logic          jok_q, jmode_q, sig_q;
  logic [33:0]   at_q;
  logic [15:0]   ent_q, tag_q;
  logic          rd_busy_q, rd_two_q, rd_ph_q, rd_done_q, rd_fail_q;
  logic [1:0]    rd_cnt_q;
  logic [AW-1:0] rd_ptr_q;
  logic [7:0]    mem [WINDOW_BYTES];
  logic [7:0]    mem_q;
  etl_status_t   out_status_q;
  logic [31:0]   out_offset_q, out_length_q;

  logic [31:0] skip_next;
  logic        jbad, jnosig, jtiff, jok_n, jmode_n, sig_n;
  logic [31:0] base_n;
  logic [7:0]  ra, rb;
  logic [34:0] rd_addr, rd_end;
  logic        rd_fail_now;

  assign skip_next = (pos_q >= RafLenPos) ? {skip_q[23:0], data_i} : skip_q;

  // JPEG / APP0 / Exif signature tracking, one byte at a time
  always_comb begin
    ra      = hrel_q - 8'd6;
    rb      = hrel_q - 8'h18;
    jbad    = 1'b0;
    jnosig  = 1'b0;
    jtiff   = 1'b0;
    jok_n   = jok_q;
    jmode_n = jmode_q;
    sig_n   = sig_q;
    base_n  = base_q;
    if (hrel_q == 8'd0) begin
      jbad = (data_i != MarkFf);
    end else if (hrel_q == 8'd1) begin
      jbad = (data_i != MarkSoi);
    end else if (hrel_q >= 8'd6) begin
      if (!jmode_q) begin
        if (hrel_q <= 8'd11) begin
          if (hrel_q < 8'd10 && data_i != jfif_byte(ra[1:0])) jok_n = 1'b0;
          if (data_i != exif_byte(ra[2:0])) sig_n = 1'b0;
          if (hrel_q == 8'd9 && jok_n) begin
            jmode_n = 1'b1;
            sig_n   = 1'b1;
          end else if (hrel_q == 8'd11) begin
            if (sig_n) begin
              jtiff  = 1'b1;
              base_n = skip_q + BaseExif;
            end else begin
              jnosig = 1'b1;
            end
          end
        end
      end else if (hrel_q >= 8'h18 && hrel_q <= 8'h1D) begin
        if (data_i != exif_byte(rb[2:0])) sig_n = 1'b0;
        if (hrel_q == 8'h1D) begin
          if (sig_n) begin
            jtiff  = 1'b1;
            base_n = skip_q + BaseJfif;
          end else begin
            jnosig = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    case (cmd_i.rd_src)
      SrcFour: rd_addr = 35'd4;
      SrcAt:   rd_addr = {1'b0, at_q};
      SrcAt8:  rd_addr = {1'b0, at_q} + 35'd8;
      default: rd_addr = 35'd4;
    endcase
    rd_end      = rd_addr + (cmd_i.rd_two ? 35'd2 : 35'd4);
    rd_fail_now = rd_end > 35'(fill_q);
  end

  always_comb begin
    sts_o.magic_match   = (data_i == raf_byte(pos_q[3:0]));
    sts_o.pos_zero      = (pos_q == 32'd0);
    sts_o.pos_magic_end = (pos_q == RafMagicEnd);
    sts_o.pos_len_end   = (pos_q == RafLenEnd);
    sts_o.skip_short    = (skip_next < RafMinSkip);
    sts_o.pos_at_skip   = (pos_q == skip_q);
    sts_o.jpeg_bad      = jbad;
    sts_o.jpeg_nosig    = jnosig;
    sts_o.jpeg_tiff     = jtiff;
    sts_o.rd_done       = rd_done_q;
    sts_o.rd_fail       = rd_fail_q;
    sts_o.ent_zero      = (ent_q == 16'd0);
    sts_o.thumb_bad     = (foff_q != 32'd0) && (fsize_q != 32'd0) &&
                          (({1'b0, foff_q} + {1'b0, fsize_q}) > len_q);
    sts_o.word_zero     = (word_q == 32'd0);
    sts_o.sub_zero      = (sub_q == 32'd0);
    sts_o.found         = (foff_q != 32'd0) && (fsize_q != 32'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      len_q     <= '0;
      skip_q    <= '0;
      base_q    <= '0;
      fill_q    <= '0;
      hrel_q    <= '0;
      jok_q     <= 1'b1;
      jmode_q   <= 1'b0;
      sig_q     <= 1'b1;
      at_q      <= '0;
      ent_q     <= '0;
      tag_q     <= '0;
      next_q    <= '0;
      sub_q     <= '0;
      foff_q    <= '0;
      fsize_q   <= '0;
      word_q    <= '0;
      rd_busy_q <= 1'b0;
      rd_two_q  <= 1'b0;
      rd_ph_q   <= 1'b0;
      rd_done_q <= 1'b0;
      rd_fail_q <= 1'b0;
      rd_cnt_q  <= '0;
      rd_ptr_q  <= '0;
    end else if (cmd_i.clear) begin
      pos_q     <= '0;
      len_q     <= '0;
      skip_q    <= '0;
      base_q    <= '0;
      fill_q    <= '0;
      hrel_q    <= '0;
      jok_q     <= 1'b1;
      jmode_q   <= 1'b0;
      sig_q     <= 1'b1;
      at_q      <= '0;
      ent_q     <= '0;
      tag_q     <= '0;
      next_q    <= '0;
      sub_q     <= '0;
      foff_q    <= '0;
      fsize_q   <= '0;
      rd_busy_q <= 1'b0;
      rd_done_q <= 1'b0;
      rd_fail_q <= 1'b0;
    end else begin
      rd_done_q <= 1'b0;
      if (cmd_i.byte_en) begin
        pos_q <= pos_q + 32'd1;
        len_q <= {1'b0, pos_q} + 33'd1;
      end
      if (cmd_i.shift_en) skip_q <= skip_next;
      if (cmd_i.jpeg_en) begin
        if (hrel_q != 8'hFF) hrel_q <= hrel_q + 8'd1;
        jok_q   <= jok_n;
        jmode_q <= jmode_n;
        sig_q   <= sig_n;
        base_q  <= base_n;
      end
      if (cmd_i.tiff_en && fill_q < FillMax) fill_q <= fill_q + FW'(1);
      if (cmd_i.at_word) at_q <= {2'b00, word_q};
      if (cmd_i.at_sub)  at_q <= {2'b00, sub_q};
      if (cmd_i.at_add2) at_q <= at_q + 34'd2;
      if (cmd_i.ent_load) ent_q <= word_q[15:0];
      if (cmd_i.tag_load) tag_q <= word_q[15:0];
      if (cmd_i.next_load) next_q <= word_q;
      if (cmd_i.ent_apply) begin
        at_q  <= at_q + 34'd12;
        ent_q <= ent_q - 16'd1;
        case (tag_q)
          TagThumbOffset: foff_q  <= base_q + word_q;
          TagThumbSize:   fsize_q <= word_q;
          TagExifIfd:     sub_q   <= word_q;
          default: ;
        endcase
      end
      // little-endian word reader; each byte waits for the registered memory read
      if (cmd_i.rd_start) begin
        word_q   <= '0;
        rd_two_q <= cmd_i.rd_two;
        rd_cnt_q <= '0;
        rd_ph_q  <= 1'b0;
        rd_ptr_q <= rd_addr[AW-1:0];
        if (rd_fail_now) begin
          rd_done_q <= 1'b1;
          rd_fail_q <= 1'b1;
        end else begin
          rd_busy_q <= 1'b1;
          rd_fail_q <= 1'b0;
        end
      end else if (rd_busy_q) begin
        if (!rd_ph_q) begin
          rd_ph_q <= 1'b1;
        end else begin
          word_q[{rd_cnt_q, 3'b000} +: 8] <= mem_q;
          rd_ph_q  <= 1'b0;
          rd_ptr_q <= rd_ptr_q + AW'(1);
          rd_cnt_q <= rd_cnt_q + 2'd1;
          if (rd_cnt_q == (rd_two_q ? 2'd1 : 2'd3)) begin
            rd_busy_q <= 1'b0;
            rd_done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tiff_en && fill_q < FillMax) mem[fill_q[AW-1:0]] <= data_i;
    mem_q <= mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_offset_q <= (cmd_i.out_status == StFound) ? foff_q : 32'd0;
      out_length_q <= (cmd_i.out_status == StFound) ? fsize_q : 32'd0;
    end
  end

  assign out_status_o = out_status_q;
  assign out_offset_o = out_offset_q;
  assign out_length_o = out_length_q;

  `ETL_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FillMax)
  `ETL_ASSERT_NXT(a_bad_read, cmd_i.rd_start && !cmd_i.clear && rd_fail_now, rd_done_q && rd_fail_q)
  `ETL_ASSERT_IMP(a_done_src, rd_done_q, $past(rd_busy_q) || $past(cmd_i.rd_start))

endmodule

>>> rtl/etl_ctrl.sv
// Controller: header phases, IFD walk sequencing and result handshake.
module etl_ctrl import etl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  etl_sts_t sts_i,
  output etl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    SMagic, SRafLen, SRafSkip, SJpeg, STiff, SDone,
    WBase, WBaseW, WCnt, WCntW, WEnt, WTag, WTagW, WVal, WValW,
    WEnd, WNext, WNextW, WSub, SEmit
  } state_e;

  state_e      state_q, state_d, ph;
  etl_status_t st_q, st_d, st_ph;
  logic [1:0]  pass_q, pass_d;
  logic        out_valid_q, out_valid_d;
  logic        in_acc;
  etl_cmd_t    cmd;

  assign in_ready_o  = (state_q inside {SMagic, SRafLen, SRafSkip, SJpeg, STiff, SDone});
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  always_comb begin
    cmd         = '0;
    cmd.rd_src  = SrcAt;
    cmd.out_status = st_q;
    state_d     = state_q;
    st_d        = st_q;
    pass_d      = pass_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ph          = state_q;
    st_ph       = st_q;

    case (state_q)
      SMagic, SRafLen, SRafSkip, SJpeg, STiff, SDone: begin
        if (in_acc) begin
          cmd.byte_en = 1'b1;
          case (state_q)
            SMagic: begin
              if (!sts_i.magic_match || in_last_i) begin
                // only a lone first byte can still open a JPEG
                if (sts_i.pos_zero) begin
                  cmd.jpeg_en = 1'b1;
                  ph = SJpeg;
                end else begin
                  ph = SDone;
                  st_ph = StNotJpeg;
                end
              end else if (sts_i.pos_magic_end) begin
                ph = SRafLen;
              end
            end
            SRafLen: begin
              cmd.shift_en = 1'b1;
              if (sts_i.pos_len_end) begin
                if (sts_i.skip_short) begin
                  ph = SDone;
                  st_ph = StWindow;
                end else begin
                  ph = SRafSkip;
                end
              end
            end
            SRafSkip: begin
              if (sts_i.pos_at_skip) begin
                cmd.jpeg_en = 1'b1;
                ph = SJpeg;
              end
            end
            SJpeg: begin
              cmd.jpeg_en = 1'b1;
            end
            STiff: begin
              cmd.tiff_en = 1'b1;
            end
            default: ;
          endcase
          if (cmd.jpeg_en) begin
            if (sts_i.jpeg_bad) begin
              ph = SDone;
              st_ph = StNotJpeg;
            end else if (sts_i.jpeg_nosig) begin
              ph = SDone;
              st_ph = StNoExif;
            end else if (sts_i.jpeg_tiff) begin
              ph = STiff;
            end
          end
          if (in_last_i) begin
            if (ph == SDone) begin
              st_d = st_ph;
              state_d = SEmit;
            end else if (ph == STiff) begin
              state_d = WBase;
            end else begin
              st_d = StWindow;
              state_d = SEmit;
            end
          end else begin
            state_d = ph;
            st_d = st_ph;
          end
        end
      end
      WBase: begin
        cmd.rd_start = 1'b1;
        cmd.rd_src = SrcFour;
        state_d = WBaseW;
      end
      WBaseW: begin
        if (sts_i.rd_done) begin
          if (sts_i.rd_fail) begin
            st_d = StWindow;
            state_d = SEmit;
          end else begin
            cmd.at_word = 1'b1;
            pass_d = 2'd0;
            state_d = WCnt;
          end
        end
      end
      WCnt: begin
        cmd.rd_start = 1'b1;
        cmd.rd_two = 1'b1;
        state_d = WCntW;
      end
      WCntW: begin
        if (sts_i.rd_done) begin
          if (sts_i.rd_fail) begin
            st_d = StWindow;
            state_d = SEmit;
          end else begin
            cmd.ent_load = 1'b1;
            cmd.at_add2 = 1'b1;
            state_d = WEnt;
          end
        end
      end
      WEnt: begin
        state_d = sts_i.ent_zero ? WEnd : WTag;
      end
      WTag: begin
        cmd.rd_start = 1'b1;
        cmd.rd_two = 1'b1;
        state_d = WTagW;
      end
      WTagW: begin
        if (sts_i.rd_done) begin
          if (sts_i.rd_fail) begin
            st_d = StWindow;
            state_d = SEmit;
          end else begin
            cmd.tag_load = 1'b1;
            state_d = WVal;
          end
        end
      end
      WVal: begin
        cmd.rd_start = 1'b1;
        cmd.rd_src = SrcAt8;
        state_d = WValW;
      end
      WValW: begin
        if (sts_i.rd_done) begin
          if (sts_i.rd_fail) begin
            st_d = StWindow;
            state_d = SEmit;
          end else begin
            cmd.ent_apply = 1'b1;
            state_d = WEnt;
          end
        end
      end
      WEnd: begin
        if (sts_i.thumb_bad) begin
          st_d = StWindow;
          state_d = SEmit;
        end else begin
          case (pass_q)
            2'd0: state_d = WNext;
            2'd1: state_d = WSub;
            default: begin
              st_d = sts_i.found ? StFound : StNone;
              state_d = SEmit;
            end
          endcase
        end
      end
      WNext: begin
        cmd.rd_start = 1'b1;
        state_d = WNextW;
      end
      WNextW: begin
        if (sts_i.rd_done) begin
          if (sts_i.rd_fail) begin
            st_d = StWindow;
            state_d = SEmit;
          end else begin
            cmd.next_load = 1'b1;
            if (sts_i.word_zero) begin
              state_d = WSub;
            end else begin
              cmd.at_word = 1'b1;
              pass_d = 2'd1;
              state_d = WCnt;
            end
          end
        end
      end
      WSub: begin
        if (sts_i.sub_zero) begin
          st_d = sts_i.found ? StFound : StNone;
          state_d = SEmit;
        end else begin
          cmd.at_sub = 1'b1;
          pass_d = 2'd2;
          state_d = WCnt;
        end
      end
      SEmit: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          cmd.clear = 1'b1;
          out_valid_d = 1'b1;
          st_d = StFound;
          pass_d = 2'd0;
          state_d = SMagic;
        end
      end
      default: state_d = SMagic;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SMagic;
      st_q        <= StFound;
      pass_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
